### rtl/drc_pkg.sv
package drc_pkg;

  localparam int COORD_BITS  = 13;
  localparam int MERGE_LIMIT = 16;
  localparam int LIST_DEPTH  = MERGE_LIMIT + 1;
  localparam int IDX_BITS    = 5;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_FULL  = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_RECT   = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  // apb byte addresses
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_w;
    logic signed [15:0] in_h;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    coord_t     rect_x;
    coord_t     rect_y;
    coord_t     rect_w;
    coord_t     rect_h;
    logic       last;
    logic       full_pending;
    logic [4:0] entry_count;
  } rsp_t;

endpackage

### rtl/drc_clip.sv
module drc_clip import drc_pkg::*; (
  input  req_t   req,
  input  coord_t screen_width,
  input  coord_t screen_height,
  output box_t   clipped,
  output logic   nonempty
);

  logic signed [17:0] x0, y0, x2, y2, sw, sh, xm, ym, cx, cy, cw, ch;

  always_comb begin
    x0 = {{2{req.in_x[15]}}, req.in_x};
    y0 = {{2{req.in_y[15]}}, req.in_y};
    x2 = x0 + {{2{req.in_w[15]}}, req.in_w};
    y2 = y0 + {{2{req.in_h[15]}}, req.in_h};
    sw = {5'b0, screen_width};
    sh = {5'b0, screen_height};
    cx = x0[17] ? 18'sd0 : x0;
    cy = y0[17] ? 18'sd0 : y0;
    xm = (x2 < sw) ? x2 : sw;
    ym = (y2 < sh) ? y2 : sh;
    cw = xm - cx;
    ch = ym - cy;
    nonempty  = !cw[17] && (cw != 18'sd0) && !ch[17] && (ch != 18'sd0);
    clipped.x = cx[COORD_BITS-1:0];
    clipped.y = cy[COORD_BITS-1:0];
    clipped.w = cw[COORD_BITS-1:0];
    clipped.h = ch[COORD_BITS-1:0];
  end

endmodule

### rtl/dirty_rect_coalescer.sv
// screen damage tracker
// req channel (req_valid/req_stall/req): one command item, accepted when
// req_valid is high and req_stall low. cmd add clips a rectangle to the
// screen and folds it into a stored list; force marks a full redraw;
// drain hands out the stored damage.
// rsp channel (rsp_valid/rsp_stall/rsp): add and force give one status
// item; drain gives one item per stored rectangle (last on the final one),
// the whole screen, or a nothing-pending item.
// the list sits in a 17-entry single-port ram with registered read data.
// an add then runs a pairwise merge pass over the ram, visiting every later
// entry for each stored entry, with up to 17 entries in the list. a drain
// reads the stored rectangles out of the ram one by one.
// one item is worked on at a time; req_stall is low only while idle.
// a stalled rsp holds its item; the block waits for the output register to
// free up before loading the next result.
// apb registers: screen_width at 0x0, screen_height at 0x4, reset to zero.
// reset (rst, synchronous) empties the list and clears the full redraw flag.
module dirty_rect_coalescer import drc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD  = 4'd1;
  localparam logic [3:0] S_LDI  = 4'd2;
  localparam logic [3:0] S_GETI = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_EV   = 4'd5;
  localparam logic [3:0] S_FINI = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;
  localparam logic [3:0] S_DRD  = 4'd9;
  localparam logic [3:0] S_DOUT = 4'd10;

  function automatic logic overlap(box_t a, box_t b);
    logic [COORD_BITS:0] ar, br, ab, bb;
    ar = {1'b0, a.x} + {1'b0, a.w};
    br = {1'b0, b.x} + {1'b0, b.w};
    ab = {1'b0, a.y} + {1'b0, a.h};
    bb = {1'b0, b.y} + {1'b0, b.h};
    return ({1'b0, a.x} < br) && ({1'b0, b.x} < ar) &&
           ({1'b0, a.y} < bb) && ({1'b0, b.y} < ab);
  endfunction

  function automatic box_t merge(box_t a, box_t b);
    logic [COORD_BITS:0] ar, br, ab, bb, rx, by;
    coord_t nx, ny;
    box_t r;
    ar = {1'b0, a.x} + {1'b0, a.w};
    br = {1'b0, b.x} + {1'b0, b.w};
    ab = {1'b0, a.y} + {1'b0, a.h};
    bb = {1'b0, b.y} + {1'b0, b.h};
    nx = (a.x < b.x) ? a.x : b.x;
    ny = (a.y < b.y) ? a.y : b.y;
    rx = (ar > br) ? ar : br;
    by = (ab > bb) ? ab : bb;
    r.x = nx;
    r.y = ny;
    r.w = COORD_BITS'(rx - {1'b0, nx});
    r.h = COORD_BITS'(by - {1'b0, ny});
    return r;
  endfunction

  logic [3:0]          state;
  coord_t              screen_width, screen_height;
  req_t                item;
  logic [IDX_BITS-1:0] cnt, i, j, wp, k, dn;
  logic                full_redraw;
  box_t                acc;
  logic [1:0]          emit_kind;
  box_t                emit_box;

  box_t                mem [LIST_DEPTH];
  box_t                rdata;
  logic                re, we;
  logic [IDX_BITS-1:0] raddr, waddr;
  box_t                wdata;

  box_t                clipped;
  logic                nonempty;
  logic                out_free;
  logic                rsp_load;
  logic                screen_zero;

  drc_clip u_clip (
    .req          (item),
    .screen_width (screen_width),
    .screen_height(screen_height),
    .clipped      (clipped),
    .nonempty     (nonempty)
  );

  assign pready      = 1'b1;
  assign req_stall   = (state != S_IDLE);
  assign out_free    = !rsp_valid || !rsp_stall;
  assign rsp_load    = ((state == S_EMIT) || (state == S_DOUT)) && out_free;
  assign screen_zero = (screen_width == '0) || (screen_height == '0);

  always_comb begin
    prdata = '0;
    prdata[COORD_BITS-1:0] = paddr[2] ? screen_height : screen_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= '0;
      screen_height <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) screen_height <= pwdata[COORD_BITS-1:0];
      else          screen_width  <= pwdata[COORD_BITS-1:0];
    end
  end

  // ram port control
  always_comb begin
    re    = 1'b0;
    raddr = i;
    we    = 1'b0;
    waddr = cnt;
    wdata = clipped;
    case (state)
      S_ADD: begin
        we = !full_redraw && !screen_zero && nonempty;
      end
      S_LDI: begin
        re = 1'b1;
      end
      S_RD: begin
        re    = 1'b1;
        raddr = j;
      end
      S_EV: begin
        we    = !overlap(acc, rdata);
        waddr = wp;
        wdata = rdata;
      end
      S_FINI: begin
        we    = 1'b1;
        waddr = i;
        wdata = acc;
      end
      S_DRD: begin
        re    = 1'b1;
        raddr = k;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      full_redraw <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item <= req;
            case (req.cmd)
              CMD_ADD: begin
                emit_kind <= KIND_STATUS;
                emit_box  <= '0;
                state     <= S_ADD;
              end
              CMD_FULL: begin
                full_redraw <= 1'b1;
                cnt         <= '0;
                emit_kind   <= KIND_STATUS;
                emit_box    <= '0;
                state       <= S_EMIT;
              end
              CMD_DRAIN: begin
                if (screen_zero) begin
                  cnt         <= '0;
                  full_redraw <= 1'b0;
                  emit_kind   <= KIND_NONE;
                  emit_box    <= '0;
                  state       <= S_EMIT;
                end else if (full_redraw) begin
                  full_redraw <= 1'b0;
                  cnt         <= '0;
                  emit_kind   <= KIND_RECT;
                  emit_box    <= '{x: '0, y: '0, w: screen_width, h: screen_height};
                  state       <= S_EMIT;
                end else if (cnt == '0) begin
                  emit_kind <= KIND_NONE;
                  emit_box  <= '0;
                  state     <= S_EMIT;
                end else begin
                  dn    <= cnt;
                  cnt   <= '0;
                  k     <= '0;
                  state <= S_DRD;
                end
              end
              default: begin
                emit_kind <= KIND_STATUS;
                emit_box  <= '0;
                state     <= S_EMIT;
              end
            endcase
          end
        end
        S_ADD: begin
          if (!full_redraw && !screen_zero && nonempty) begin
            cnt   <= cnt + 1'b1;
            i     <= '0;
            state <= S_LDI;
          end else begin
            state <= S_EMIT;
          end
        end
        S_LDI: state <= S_GETI;
        S_GETI: begin
          acc   <= rdata;
          j     <= i + 1'b1;
          wp    <= i + 1'b1;
          state <= (i + 1'b1 < cnt) ? S_RD : S_FINI;
        end
        S_RD: state <= S_EV;
        S_EV: begin
          // survivors are compacted down to wp as the scan moves on
          if (overlap(acc, rdata)) acc <= merge(acc, rdata);
          else                     wp  <= wp + 1'b1;
          j     <= j + 1'b1;
          state <= (j + 1'b1 < cnt) ? S_RD : S_FINI;
        end
        S_FINI: begin
          cnt   <= wp;
          i     <= i + 1'b1;
          state <= (i + 1'b1 < wp) ? S_LDI : S_CHK;
        end
        S_CHK: begin
          if (cnt > IDX_BITS'(MERGE_LIMIT)) begin
            full_redraw <= 1'b1;
            cnt         <= '0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_valid        <= 1'b1;
            rsp.kind         <= emit_kind;
            rsp.rect_x       <= emit_box.x;
            rsp.rect_y       <= emit_box.y;
            rsp.rect_w       <= emit_box.w;
            rsp.rect_h       <= emit_box.h;
            rsp.last         <= 1'b1;
            rsp.full_pending <= full_redraw;
            rsp.entry_count  <= cnt;
            state            <= S_IDLE;
          end
        end
        S_DRD: state <= S_DOUT;
        S_DOUT: begin
          if (out_free) begin
            rsp_valid        <= 1'b1;
            rsp.kind         <= KIND_RECT;
            rsp.rect_x       <= rdata.x;
            rsp.rect_y       <= rdata.y;
            rsp.rect_w       <= rdata.w;
            rsp.rect_h       <= rdata.h;
            rsp.last         <= (k + 1'b1 == dn);
            rsp.full_pending <= full_redraw;
            rsp.entry_count  <= cnt;
            k                <= k + 1'b1;
            state            <= (k + 1'b1 == dn) ? S_IDLE : S_DRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/drc_checker.sv
module drc_props import drc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp item changed");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("req taken while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == KIND_STATUS || rsp.kind == KIND_NONE) |->
      rsp.last && rsp.rect_x == '0 && rsp.rect_y == '0 &&
      rsp.rect_w == '0 && rsp.rect_h == '0)
    else $error("status item carries a rectangle");

  // a drain's rectangle items always show the list empty and no full redraw pending
  a_drain: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_RECT |->
      rsp.entry_count == '0 && !rsp.full_pending)
    else $error("drain left state behind");

endmodule

bind dirty_rect_coalescer drc_props u_drc_props (.*);

### tb/drc_checker.sv
`timescale 1ns / 100ps
module drc_checker import drc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output int          rects_seen
);

  int scr_w, scr_h;
  int bx[LIST_DEPTH], by[LIST_DEPTH], bw[LIST_DEPTH], bh[LIST_DEPTH];
  int n_boxes;
  bit full_redraw;
  rsp_t damage_q[$];

  function automatic int imin(int a, int b);
    return a < b ? a : b;
  endfunction

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic void queue_result(logic [1:0] kind, int x, int y, int w, int h, bit lst);
    rsp_t r;
    r.kind = kind;
    r.rect_x = coord_t'(x);
    r.rect_y = coord_t'(y);
    r.rect_w = coord_t'(w);
    r.rect_h = coord_t'(h);
    r.last = lst;
    r.full_pending = full_redraw;
    r.entry_count = n_boxes[4:0];
    damage_q = {damage_q, r};
  endfunction

  function automatic bit boxes_overlap(int a, int b);
    return bx[a] < bx[b] + bw[b] && bx[b] < bx[a] + bw[a] &&
           by[a] < by[b] + bh[b] && by[b] < by[a] + bh[a];
  endfunction

  function automatic void add_damage(int x, int y, int w, int h);
    int cx, cy, cw, ch, rx, ry, j;
    if (full_redraw || scr_w == 0 || scr_h == 0) return;
    cx = imax(x, 0);
    cy = imax(y, 0);
    cw = imin(x + w, scr_w) - cx;
    ch = imin(y + h, scr_h) - cy;
    if (cw <= 0 || ch <= 0) return;
    bx[n_boxes] = cx; by[n_boxes] = cy; bw[n_boxes] = cw; bh[n_boxes] = ch;
    n_boxes++;
    // single ordered pass, later boxes fold into earlier ones
    for (int i = 0; i < n_boxes; i++) begin
      j = i + 1;
      while (j < n_boxes) begin
        if (boxes_overlap(i, j)) begin
          rx = imax(bx[i] + bw[i], bx[j] + bw[j]);
          ry = imax(by[i] + bh[i], by[j] + bh[j]);
          bx[i] = imin(bx[i], bx[j]);
          by[i] = imin(by[i], by[j]);
          bw[i] = rx - bx[i];
          bh[i] = ry - by[i];
          for (int k = j; k < n_boxes - 1; k++) begin
            bx[k] = bx[k+1]; by[k] = by[k+1]; bw[k] = bw[k+1]; bh[k] = bh[k+1];
          end
          n_boxes--;
        end else begin
          j++;
        end
      end
    end
    if (n_boxes > MERGE_LIMIT) begin
      full_redraw = 1;
      n_boxes = 0;
    end
  endfunction

  function automatic void predict_damage(req_t r);
    int n;
    case (r.cmd)
      CMD_ADD: begin
        add_damage(int'(r.in_x), int'(r.in_y), int'(r.in_w), int'(r.in_h));
        queue_result(KIND_STATUS, 0, 0, 0, 0, 1);
      end
      CMD_FULL: begin
        full_redraw = 1;
        n_boxes = 0;
        queue_result(KIND_STATUS, 0, 0, 0, 0, 1);
      end
      CMD_DRAIN: begin
        if (scr_w == 0 || scr_h == 0) begin
          n_boxes = 0;
          full_redraw = 0;
          queue_result(KIND_NONE, 0, 0, 0, 0, 1);
        end else if (full_redraw) begin
          full_redraw = 0;
          n_boxes = 0;
          queue_result(KIND_RECT, 0, 0, scr_w, scr_h, 1);
        end else if (n_boxes == 0) begin
          queue_result(KIND_NONE, 0, 0, 0, 0, 1);
        end else begin
          n = n_boxes;
          n_boxes = 0;
          for (int k = 0; k < n; k++)
            queue_result(KIND_RECT, bx[k], by[k], bw[k], bh[k], k + 1 == n);
        end
      end
      default: queue_result(KIND_STATUS, 0, 0, 0, 0, 1);
    endcase
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    rects_seen = 0;
    scr_w = 0;
    scr_h = 0;
    n_boxes = 0;
    full_redraw = 0;
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      n_boxes = 0;
      full_redraw = 0;
      scr_w = 0;
      scr_h = 0;
      damage_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_SCREEN_WIDTH) scr_w = int'(pwdata[12:0]);
        else if (paddr == REG_SCREEN_HEIGHT) scr_h = int'(pwdata[12:0]);
      end
      if (req_valid && !req_stall) predict_damage(req);
      if (rsp_valid && !rsp_stall) begin
        if (rsp.kind == KIND_RECT) rects_seen++;
        if (damage_q.size() == 0) begin
          $error("unexpected result item kind %0d", rsp.kind);
          errors++;
        end else begin
          e = damage_q[0];
          damage_q.delete(0);
          check_field("kind", e.kind, rsp.kind);
          check_field("rect_x", e.rect_x, rsp.rect_x);
          check_field("rect_y", e.rect_y, rsp.rect_y);
          check_field("rect_w", e.rect_w, rsp.rect_w);
          check_field("rect_h", e.rect_h, rsp.rect_h);
          check_field("last", e.last, rsp.last);
          check_field("full_pending", e.full_pending, rsp.full_pending);
          check_field("entry_count", e.entry_count, rsp.entry_count);
        end
      end
    end
    pending = damage_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import drc_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int HANG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int errors, pending, rects_seen;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit no_idle = 0;

  always #5 clk = ~clk;

  dirty_rect_coalescer uut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  drc_checker chk (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending, .rects_seen
  );

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("dirty_rect_coalescer: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stalls in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, int value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(req_t r);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    items_sent++;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic send_cmd(logic [1:0] c, int x, int y, int w, int h);
    req_t r;
    r.cmd = c; r.in_x = 16'(x); r.in_y = 16'(y); r.in_w = 16'(w); r.in_h = 16'(h);
    send_item(r);
  endtask

  task automatic drain_all();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_screen(int w, int h);
    drain_all();
    reg_write(REG_SCREEN_WIDTH, w);
    reg_write(REG_SCREEN_HEIGHT, h);
  endtask

  task automatic random_items(int count, int w, int h);
    req_t r;
    int sel, sw, sh;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      sw = w > 0 ? w : 64;
      sh = h > 0 ? h : 64;
      r.in_x = 16'($urandom); r.in_y = 16'($urandom);
      r.in_w = 16'($urandom); r.in_h = 16'($urandom);
      if (sel < 70) begin
        // mostly small boxes on screen so the list fills before merging
        r.cmd = CMD_ADD;
        r.in_x = 16'($urandom_range(0, sw + 4) - 4);
        r.in_y = 16'($urandom_range(0, sh + 4) - 4);
        r.in_w = 16'($urandom_range(0, 3) == 0 ? $urandom_range(1, sw) :
                     $urandom_range(0, sw / 16 + 2));
        r.in_h = 16'($urandom_range(0, 3) == 0 ? $urandom_range(1, sh) :
                     $urandom_range(0, sh / 16 + 2));
      end else if (sel < 80) r.cmd = CMD_ADD;
      else if (sel < 93) r.cmd = CMD_DRAIN;
      else if (sel < 97) r.cmd = CMD_FULL;
      else r.cmd = CMD_UNUSED;
      send_item(r);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero screen: adds ignored, drains report nothing and clear state
    send_cmd(CMD_ADD, 0, 0, 10, 10);
    send_cmd(CMD_FULL, 0, 0, 0, 0);
    send_cmd(CMD_DRAIN, 0, 0, 0, 0);
    set_screen(4096, 4096);
    send_cmd(CMD_DRAIN, 0, 0, 0, 0);
    send_cmd(CMD_ADD, -32768, -32768, 32767, 32767);
    send_cmd(CMD_ADD, 32767, 32767, 32767, 32767);
    send_cmd(CMD_ADD, 10, 10, 0, 5);
    send_cmd(CMD_ADD, 10, 10, 5, -32768);
    send_cmd(CMD_ADD, -100, -100, 32767, 32767);
    send_cmd(CMD_DRAIN, 0, 0, 0, 0);
    send_cmd(CMD_ADD, 0, 0, 10, 10);
    send_cmd(CMD_ADD, 10, 0, 10, 10);
    send_cmd(CMD_ADD, 5, 5, 10, 10);
    send_cmd(CMD_ADD, 4095, 4095, 1, 1);
    send_cmd(CMD_DRAIN, 0, 0, 0, 0);
    for (int k = 0; k < 17; k++) send_cmd(CMD_ADD, 100 * k, 100 * k, 2, 2);
    send_cmd(CMD_ADD, 0, 0, 5, 5);
    send_cmd(CMD_DRAIN, 0, 0, 0, 0);
    send_cmd(CMD_FULL, 0, 0, 0, 0);
    send_cmd(CMD_UNUSED, 0, 0, 0, 0);
    send_cmd(CMD_DRAIN, 0, 0, 0, 0);

    random_items(80, 4096, 4096);
    drain_all();
    random_items(70, 4096, 4096);
    set_screen(640, 480);
    random_items(100, 640, 480);
    set_screen(1, 1);
    random_items(30, 1, 1);
    set_screen(4096, 0);
    random_items(20, 4096, 0);
    set_screen(0, 300);
    random_items(15, 0, 300);
    set_screen(200, 150);
    no_idle = 1;
    random_items(118, 200, 150);

    drain_all();
    $display("sent %0d command items, %0d damage rectangles came back", items_sent,
             rects_seen);
    $display("screens 0, 1x1, 640x480, 200x150 and 4096x4096, stalls on both sides");
    if (errors == 0) begin
      $display("dirty_rect_coalescer: match");
    end else begin
      $display("dirty_rect_coalescer: mismatch");
    end
    $finish;
  end

endmodule
